// ===== rtl/core/sacl_pkg.sv =====
`timescale 1ns / 1ps

package sacl_pkg;

  // field widths of the transactions
  localparam int ADDR_W  = 48;
  localparam int CNT_W   = 32;
  localparam int STAT_W  = 3;

  // parameter defaults
  localparam int ADDR_BITS_DEF    = 48;
  localparam int SET_BITS_MAX_DEF = 6;
  localparam int WAYS_DEF         = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_BLOCK_BITS  = 2'd0;
  localparam logic [1:0] CFG_SET_BITS    = 2'd1;
  localparam logic [1:0] CFG_WAYS_IN_USE = 2'd2;

  // configuration reset values
  localparam logic [4:0] BLOCK_BITS_RST  = 5'd4;
  localparam logic [2:0] SET_BITS_RST    = 3'd6;
  localparam logic [2:0] WAYS_IN_USE_RST = 3'd4;

  // request kinds
  localparam logic REQ_ACCESS = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  // result codes
  localparam logic [STAT_W-1:0] STAT_HIT       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_MISS      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EVICT     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FLUSHED   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] addr;
  } sacl_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] evicted_blk;
    logic [ADDR_W-1:0] filled_blk;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
    logic [CNT_W-1:0]  evict_total;
  } sacl_rsp_t;

  // outcome of one set update
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              hit;
    logic              miss;
    logic              evict;
  } sacl_flags_t;

endpackage

// ===== rtl/core/set_associative_cache_lru.sv =====
`timescale 1ns / 1ps

// Tag store of a set-associative cache with least-recently-used replacement.
// An access (req_type 0) splits addr into block offset, set index and tag,
// reports hit, miss or miss with eviction, and gives the filled and evicted
// block addresses; a flush (req_type 1) invalidates the matching line. Hit,
// miss and eviction totals saturate at 2^32-1 and come with every result.
// Each set lives as one row of a single-port-per-direction synchronous
// memory: the set is read when the transaction is accepted and is updated
// and written back on commit in the lookup state, once the output register
// is free to take the result. After reset a clearing pass writes all
// 2^SET_BITS_MAX rows (64 by default) once before the first request
// transaction is taken; configuration writes are taken at any time and
// must only be issued while the block is idle.

module set_associative_cache_lru import sacl_pkg::*; #(
  parameter int ADDR_BITS    = ADDR_BITS_DEF,
  parameter int SET_BITS_MAX = SET_BITS_MAX_DEF,
  parameter int WAYS         = WAYS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sacl_req_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output sacl_rsp_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);

  // address bits actually held in the store
  localparam int AW     = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int NSETS  = 1 << SET_BITS_MAX;
  localparam int IDX_W  = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
  localparam int AGE_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NW_W   = $clog2(WAYS + 1);
  localparam int WAY_W  = 2 * AW + AGE_W + 1;
  localparam int ROW_W  = WAYS * WAY_W;
  localparam logic [IDX_W-1:0] LAST_SET = IDX_W'(NSETS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [4:0] block_bits_r;
  logic [2:0] set_bits_r, ways_r;

  // clearing pass
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;

  // request held across the read
  logic             flush_r;
  logic [AW-1:0]    tag_r, blk_r;
  logic [IDX_W-1:0] set_r;
  logic [NW_W-1:0]  nw_r;

  // counters and result register
  logic [CNT_W-1:0] hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic [CNT_W-1:0] hit_cnt_nxt, miss_cnt_nxt, evict_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  sacl_rsp_t        out_data_r;

  // address decode at acceptance
  logic [3:0]       sb;
  logic [5:0]       tag_sh;
  logic [AW-1:0]    addr_a, tag_a, blk_a;
  logic [IDX_W-1:0] set_a;
  logic [NW_W-1:0]  nw_a;

  // memory and update
  logic             accept, commit;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_idx;
  logic [ROW_W-1:0] mem_wr_data, mem_rd_data, row_new;
  logic [AW-1:0]    victim;
  sacl_flags_t      flags;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign commit    = (state_r == ST_LOOK) && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // geometry in effect, out-of-range settings clamped
  always_comb begin
    if (int'(set_bits_r) > SET_BITS_MAX) begin
      sb = 4'(SET_BITS_MAX);
    end else begin
      sb = {1'b0, set_bits_r};
    end
    if (ways_r == 3'd0) begin
      nw_a = NW_W'(1);
    end else if (int'(ways_r) > WAYS) begin
      nw_a = NW_W'(WAYS);
    end else begin
      nw_a = NW_W'(ways_r);
    end
    addr_a = in_data.addr[AW-1:0];
    tag_sh = {1'b0, block_bits_r} + {2'b00, sb};
    set_a  = IDX_W'(addr_a >> block_bits_r) & ~({IDX_W{1'b1}} << sb);
    tag_a  = addr_a >> tag_sh;
    blk_a  = (addr_a >> block_bits_r) << block_bits_r;
  end

  sacl_mem #(
    .DEPTH (NSETS),
    .IDX_W (IDX_W),
    .ROW_W (ROW_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_idx  (set_a),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_idx  (mem_wr_idx),
    .wr_data (mem_wr_data)
  );

  sacl_upd #(
    .WAYS  (WAYS),
    .AW    (AW),
    .AGE_W (AGE_W),
    .NW_W  (NW_W),
    .WAY_W (WAY_W),
    .ROW_W (ROW_W)
  ) u_upd (
    .row_i    (mem_rd_data),
    .flush_i  (flush_r),
    .tag_i    (tag_r),
    .blk_i    (blk_r),
    .nw_i     (nw_r),
    .row_o    (row_new),
    .victim_o (victim),
    .flags_o  (flags)
  );

  // write port: zero rows during the clearing pass, updated set on commit
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_idx  = set_r;
    mem_wr_data = row_new;
    if (state_r == ST_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_idx  = clr_idx_r;
      mem_wr_data = '0;
    end else if (commit) begin
      mem_wr_en = 1'b1;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_SET) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // saturating totals
  always_comb begin
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    evict_cnt_nxt = evict_cnt_r;
    if (flags.hit && hit_cnt_r != '1) begin
      hit_cnt_nxt = hit_cnt_r + 1'b1;
    end
    if (flags.miss && miss_cnt_r != '1) begin
      miss_cnt_nxt = miss_cnt_r + 1'b1;
    end
    if (flags.evict && evict_cnt_r != '1) begin
      evict_cnt_nxt = evict_cnt_r + 1'b1;
    end
  end

  always_comb begin
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_idx_r    <= '0;
      out_valid_r  <= 1'b0;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
      evict_cnt_r  <= '0;
      block_bits_r <= BLOCK_BITS_RST;
      set_bits_r   <= SET_BITS_RST;
      ways_r       <= WAYS_IN_USE_RST;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        evict_cnt_r <= evict_cnt_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_BLOCK_BITS:  block_bits_r <= cfg_data;
          CFG_SET_BITS:    set_bits_r   <= cfg_data[2:0];
          CFG_WAYS_IN_USE: ways_r       <= cfg_data[2:0];
          default: begin
            // no register behind this index
          end
        endcase
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      flush_r <= in_data.req_type;
      tag_r   <= tag_a;
      blk_r   <= blk_a;
      set_r   <= set_a;
      nw_r    <= nw_a;
    end
    if (commit) begin
      out_data_r.status      <= flags.status;
      out_data_r.evicted_blk <= ADDR_W'(victim);
      out_data_r.filled_blk  <= flags.miss ? ADDR_W'(blk_r) : '0;
      out_data_r.hit_total   <= hit_cnt_nxt;
      out_data_r.miss_total  <= miss_cnt_nxt;
      out_data_r.evict_total <= evict_cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  // the store is never written while waiting for a request
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> state_r != ST_IDLE)
    else $error("tag memory written while idle");

  // an accepted transaction is always followed by its lookup cycle
  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_LOOK)
    else $error("accepted transaction not looked up");

  // a new result only appears out of a lookup
  a_result_from_look: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_LOOK))
    else $error("result raised without lookup");

  // totals never fall between resets
  a_totals_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (hit_cnt_r >= $past(hit_cnt_r)) && (miss_cnt_r >= $past(miss_cnt_r))
                     && (evict_cnt_r >= $past(evict_cnt_r)))
    else $error("total decreased");
`endif

endmodule

// ===== rtl/core/sacl_mem.sv =====
`timescale 1ns / 1ps

module sacl_mem #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6,
  parameter int ROW_W = 8
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [ROW_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [ROW_W-1:0] wr_data
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/sacl_upd.sv =====
`timescale 1ns / 1ps

module sacl_upd import sacl_pkg::*; #(
  parameter int WAYS  = 4,
  parameter int AW    = 48,
  parameter int AGE_W = 2,
  parameter int NW_W  = 3,
  parameter int WAY_W = 2 * AW + AGE_W + 1,
  parameter int ROW_W = WAYS * WAY_W
) (
  input  logic [ROW_W-1:0] row_i,
  input  logic             flush_i,
  input  logic [AW-1:0]    tag_i,
  input  logic [AW-1:0]    blk_i,
  input  logic [NW_W-1:0]  nw_i,
  output logic [ROW_W-1:0] row_o,
  output logic [AW-1:0]    victim_o,
  output sacl_flags_t      flags_o
);

  localparam int WI_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [AGE_W-1:0] AGE_TOP = AGE_W'(WAYS - 1);

  logic             v     [WAYS];
  logic [AGE_W-1:0] age   [WAYS];
  logic [AW-1:0]    tg    [WAYS];
  logic [AW-1:0]    bk    [WAYS];
  logic             nv    [WAYS];
  logic [AGE_W-1:0] nage  [WAYS];
  logic [AW-1:0]    ntg   [WAYS];
  logic [AW-1:0]    nbk   [WAYS];
  logic             in_use [WAYS];

  logic             hit_found, free_found;
  logic [WI_W-1:0]  hit_way, free_way, vic_way, sel_way;
  logic [AGE_W-1:0] best, rank;
  logic             rank_lim;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      bk[w]     = row_i[w*WAY_W +: AW];
      tg[w]     = row_i[w*WAY_W + AW +: AW];
      age[w]    = row_i[w*WAY_W + 2*AW +: AGE_W];
      v[w]      = row_i[w*WAY_W + 2*AW + AGE_W];
      in_use[w] = (w < int'(nw_i));
    end

    // lowest matching way and lowest free way
    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (in_use[w] && v[w] && tg[w] == tag_i) begin
        hit_found = 1'b1;
        hit_way   = WI_W'(w);
      end
      if (in_use[w] && !v[w]) begin
        free_found = 1'b1;
        free_way   = WI_W'(w);
      end
    end

    // oldest way, lowest first among equals
    best    = '0;
    vic_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (in_use[w] && age[w] > best) begin
        best    = age[w];
        vic_way = WI_W'(w);
      end
    end

    for (int w = 0; w < WAYS; w++) begin
      nv[w]   = v[w];
      nage[w] = age[w];
      ntg[w]  = tg[w];
      nbk[w]  = bk[w];
    end

    flags_o  = '0;
    victim_o = '0;
    sel_way  = hit_way;
    rank     = age[hit_way];
    rank_lim = 1'b1;

    if (flush_i == REQ_FLUSH) begin
      if (hit_found) begin
        nv[hit_way]   = 1'b0;
        nage[hit_way] = '0;
        for (int w = 0; w < WAYS; w++) begin
          if (in_use[w] && v[w] && WI_W'(w) != hit_way && age[w] > rank) begin
            nage[w] = age[w] - 1'b1;
          end
        end
        flags_o.status = STAT_FLUSHED;
      end else begin
        flags_o.status = STAT_NOT_FOUND;
      end
    end else begin
      if (hit_found) begin
        flags_o.status = STAT_HIT;
        flags_o.hit    = 1'b1;
      end else begin
        rank_lim     = 1'b0;
        flags_o.miss = 1'b1;
        if (free_found) begin
          sel_way        = free_way;
          flags_o.status = STAT_MISS;
        end else begin
          sel_way        = vic_way;
          victim_o       = bk[vic_way];
          flags_o.status = STAT_EVICT;
          flags_o.evict  = 1'b1;
        end
      end
      // selected way newest; younger ways age by one, all on miss
      for (int w = 0; w < WAYS; w++) begin
        if (in_use[w] && v[w] && WI_W'(w) != sel_way && (!rank_lim || age[w] < rank) &&
            age[w] < AGE_TOP) begin
          nage[w] = age[w] + 1'b1;
        end
      end
      nage[sel_way] = '0;
      if (!hit_found) begin
        nv[sel_way]  = 1'b1;
        ntg[sel_way] = tag_i;
        nbk[sel_way] = blk_i;
      end
    end

    for (int w = 0; w < WAYS; w++) begin
      row_o[w*WAY_W +: WAY_W] = {nv[w], nage[w], ntg[w], nbk[w]};
    end
  end

endmodule
